@@ src/dme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dme_pkg
// Shared types, constants and interface structs of the depth-first maze
// explorer: grid geometry, direction codes, sequencer states.
// ----------------------------------------------------------------------------
package dme_pkg;

	localparam int COORD_BITS     = 4;
	localparam int SIDE           = 1 << COORD_BITS;
	localparam int CELL_BITS      = 2 * COORD_BITS;
	localparam int GRID_CELLS     = 1 << CELL_BITS;
	localparam int DEPTH_BITS     = CELL_BITS + 1;
	localparam int OPEN_BITS      = 4;
	localparam int CFG_IDX_BITS   = 1;
	localparam int IN_TDATA_W     = ((OPEN_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 2 + 2 * COORD_BITS + DEPTH_BITS;
	localparam int OUT_TDATA_W    = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_TUSER_W    = 2;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [CELL_BITS-1:0]  cell_t;
	typedef logic [DEPTH_BITS-1:0] depth_t;
	typedef logic [SIDE-1:0]       row_t;
	typedef logic [OPEN_BITS-1:0]  open_t;

	localparam coord_t START_DEFAULT = coord_t'(1);
	localparam depth_t STACK_FULL    = depth_t'(GRID_CELLS);

	typedef enum logic [1:0] {
		DIR_N = 2'd0,
		DIR_E = 2'd1,
		DIR_S = 2'd2,
		DIR_W = 2'd3
	} dir_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_START_ROW = 1'b0,
		CFG_START_COL = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW,
		ST_DEC,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic   re_a;
		logic   re_b;
		coord_t rd_a_addr;
		coord_t rd_b_addr;
		logic   we;
		coord_t wr_addr;
		row_t   wr_data;
	} vis_req_t;

	typedef struct packed {
		logic  opn_re;
		cell_t opn_raddr;
		logic  opn_we;
		cell_t opn_waddr;
		open_t opn_wdata;
		logic  stk_re;
		cell_t stk_raddr;
		logic  stk_we;
		cell_t stk_waddr;
		cell_t stk_wdata;
	} store_req_t;

	typedef struct packed {
		dir_t   move_dir;
		logic   backtracked;
		logic   explore_done;
		coord_t new_row;
		coord_t new_col;
		depth_t mapped_cells;
	} result_t;

endpackage

@@ src/dme_visited.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dme_visited
// Visited map stored as one row of cells per memory word, two read ports
// and one write port; a per-row valid bit makes unwritten rows read as zero.
// ----------------------------------------------------------------------------
module dme_visited import dme_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  vis_req_t req,
	output row_t     rd_a,
	output row_t     rd_b
);

	row_t            row_mem_q [SIDE];
	logic [SIDE-1:0] row_valid_q;
	row_t            rd_a_q;
	row_t            rd_b_q;
	logic            rd_a_valid_q;
	logic            rd_b_valid_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			row_mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.re_a) begin
			rd_a_q <= row_mem_q[req.rd_a_addr];
		end
		if (req.re_b) begin
			rd_b_q <= row_mem_q[req.rd_b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q  <= '0;
			rd_a_valid_q <= 1'b0;
			rd_b_valid_q <= 1'b0;
		end else begin
			if (req.we) begin
				row_valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.re_a) begin
				rd_a_valid_q <= row_valid_q[req.rd_a_addr];
			end
			if (req.re_b) begin
				rd_b_valid_q <= row_valid_q[req.rd_b_addr];
			end
		end
	end

	assign rd_a = rd_a_valid_q ? rd_a_q : '0;
	assign rd_b = rd_b_valid_q ? rd_b_q : '0;

endmodule

@@ src/dme_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dme_store
// Per-cell openings memory and path stack memory, each with one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module dme_store import dme_pkg::*; (
	input  logic       clk,
	input  store_req_t req,
	output open_t      opn_rdata,
	output cell_t      stk_rdata
);

	open_t opn_mem_q [GRID_CELLS];
	cell_t stk_mem_q [GRID_CELLS];
	open_t opn_rdata_q;
	cell_t stk_rdata_q;

	always_ff @(posedge clk) begin
		if (req.opn_we) begin
			opn_mem_q[req.opn_waddr] <= req.opn_wdata;
		end
		if (req.opn_re) begin
			opn_rdata_q <= opn_mem_q[req.opn_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.stk_we) begin
			stk_mem_q[req.stk_waddr] <= req.stk_wdata;
		end
		if (req.stk_re) begin
			stk_rdata_q <= stk_mem_q[req.stk_raddr];
		end
	end

	assign opn_rdata = opn_rdata_q;
	assign stk_rdata = stk_rdata_q;

endmodule

@@ src/dme_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dme_seq
// Step sequencer: reads the neighbour rows and stored openings, picks the
// next move, writes back the map, openings and path stack, and resolves
// the backstep target from the stack.
// ----------------------------------------------------------------------------
module dme_seq import dme_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  coord_t     start_row,
	input  coord_t     start_col,
	input  logic       item_valid,
	input  open_t      item_openings,
	output logic       item_take,
	output logic       res_valid,
	input  logic       res_ready,
	output result_t    res,
	output vis_req_t   vis_req,
	input  row_t       vis_rd_a,
	input  row_t       vis_rd_b,
	output store_req_t st_req,
	input  open_t      opn_rdata,
	input  cell_t      stk_rdata
);

	seq_state_t state_q, state_nxt;
	logic       started_q;
	logic       finished_q;
	logic       back_arr_q;
	coord_t     cur_row_q;
	coord_t     cur_col_q;
	depth_t     stack_depth_q;
	depth_t     cell_count_q;
	open_t      item_open_q;
	row_t       row_n_q;
	row_t       row_s_q;
	dir_t       res_dir_q;
	logic       res_back_q;
	logic       res_done_q;

	coord_t eff_row, eff_col;
	open_t  open_eff;
	coord_t col_inc, col_dec, row_inc, row_dec;
	logic   can_n, can_e, can_s, can_w, moved;
	dir_t   pick_dir;
	logic   push, here_new;
	depth_t depth1, depth2, depth_m1;
	row_t   row_r;
	coord_t prev_row, prev_col;
	dir_t   back_dir;
	logic   res_fire;

	// current cell, with the start cell on the very first step
	assign eff_row = started_q ? cur_row_q : start_row;
	assign eff_col = started_q ? cur_col_q : start_col;

	assign row_r    = vis_rd_a;
	assign open_eff = back_arr_q ? opn_rdata : item_open_q;
	assign col_inc  = cur_col_q + coord_t'(1);
	assign col_dec  = cur_col_q - coord_t'(1);
	assign row_inc  = cur_row_q + coord_t'(1);
	assign row_dec  = cur_row_q - coord_t'(1);

	// grid edges count as walls
	assign can_n = open_eff[DIR_N] && (cur_row_q != '0) && !row_n_q[cur_col_q];
	assign can_e = open_eff[DIR_E] && (cur_col_q != '1) && !row_r[col_inc];
	assign can_s = open_eff[DIR_S] && (cur_row_q != '1) && !row_s_q[cur_col_q];
	assign can_w = open_eff[DIR_W] && (cur_col_q != '0) && !row_r[col_dec];
	assign moved = can_n || can_e || can_s || can_w;

	always_comb begin
		if (can_n) begin
			pick_dir = DIR_N;
		end else if (can_e) begin
			pick_dir = DIR_E;
		end else if (can_s) begin
			pick_dir = DIR_S;
		end else begin
			pick_dir = DIR_W;
		end
	end

	assign push     = !back_arr_q && (stack_depth_q != STACK_FULL);
	assign here_new = !back_arr_q && !row_r[cur_col_q];
	assign depth1   = stack_depth_q + depth_t'(push);
	assign depth2   = (moved || depth1 == '0) ? depth1 : depth1 - depth_t'(1);
	assign depth_m1 = depth2 - depth_t'(1);

	// backstep target from the stack
	assign prev_row = stk_rdata[CELL_BITS-1:COORD_BITS];
	assign prev_col = stk_rdata[COORD_BITS-1:0];

	always_comb begin
		if (cur_row_q != '0 && prev_row == row_dec && prev_col == cur_col_q) begin
			back_dir = DIR_N;
		end else if (cur_col_q != '1 && prev_row == cur_row_q && prev_col == col_inc) begin
			back_dir = DIR_E;
		end else if (cur_row_q != '1 && prev_row == row_inc && prev_col == cur_col_q) begin
			back_dir = DIR_S;
		end else if (cur_col_q != '0 && prev_row == cur_row_q && prev_col == col_dec) begin
			back_dir = DIR_W;
		end else begin
			back_dir = DIR_N;
		end
	end

	assign res_fire = res_valid && res_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_nxt = finished_q ? ST_OUT : ST_ROW;
				end
			end
			ST_ROW:  state_nxt = ST_DEC;
			ST_DEC:  state_nxt = ST_OUT;
			ST_OUT: begin
				if (res_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs and memory requests
	always_comb begin
		item_take         = 1'b0;
		res_valid         = 1'b0;
		vis_req           = '0;
		st_req            = '0;
		vis_req.rd_a_addr = eff_row - coord_t'(1);
		vis_req.rd_b_addr = eff_row + coord_t'(1);
		vis_req.wr_addr   = cur_row_q;
		vis_req.wr_data   = row_r;
		vis_req.wr_data[cur_col_q] = 1'b1;
		st_req.opn_raddr  = {eff_row, eff_col};
		st_req.opn_waddr  = {cur_row_q, cur_col_q};
		st_req.opn_wdata  = item_open_q;
		st_req.stk_raddr  = depth_m1[CELL_BITS-1:0];
		st_req.stk_waddr  = stack_depth_q[CELL_BITS-1:0];
		st_req.stk_wdata  = {cur_row_q, cur_col_q};
		case (state_q)
			ST_IDLE: begin
				item_take = item_valid;
				if (item_valid && !finished_q) begin
					vis_req.re_a  = 1'b1;
					vis_req.re_b  = 1'b1;
					st_req.opn_re = 1'b1;
				end
			end
			ST_ROW: begin
				vis_req.re_a      = 1'b1;
				vis_req.rd_a_addr = cur_row_q;
			end
			ST_DEC: begin
				vis_req.we    = !back_arr_q;
				st_req.opn_we = !back_arr_q;
				st_req.stk_we = push;
				st_req.stk_re = !moved && (depth2 != '0);
			end
			ST_OUT: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res.move_dir     = res_back_q ? back_dir : res_dir_q;
	assign res.backtracked  = res_back_q;
	assign res.explore_done = res_done_q;
	assign res.new_row      = res_back_q ? prev_row : cur_row_q;
	assign res.new_col      = res_back_q ? prev_col : cur_col_q;
	assign res.mapped_cells = cell_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			started_q     <= 1'b0;
			finished_q    <= 1'b0;
			back_arr_q    <= 1'b0;
			cur_row_q     <= '0;
			cur_col_q     <= '0;
			stack_depth_q <= '0;
			cell_count_q  <= '0;
			res_dir_q     <= DIR_N;
			res_back_q    <= 1'b0;
			res_done_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						res_dir_q  <= DIR_N;
						res_back_q <= 1'b0;
						res_done_q <= finished_q;
						if (!finished_q && !started_q) begin
							started_q  <= 1'b1;
							cur_row_q  <= start_row;
							cur_col_q  <= start_col;
							back_arr_q <= 1'b0;
						end
					end
				end
				ST_DEC: begin
					stack_depth_q <= depth2;
					if (here_new) begin
						cell_count_q <= cell_count_q + depth_t'(1);
					end
					if (moved) begin
						res_dir_q  <= pick_dir;
						back_arr_q <= 1'b0;
						case (pick_dir)
							DIR_N:   cur_row_q <= row_dec;
							DIR_E:   cur_col_q <= col_inc;
							DIR_S:   cur_row_q <= row_inc;
							default: cur_col_q <= col_dec;
						endcase
					end else if (depth2 == '0) begin
						finished_q <= 1'b1;
						res_done_q <= 1'b1;
					end else begin
						res_back_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (res_fire && res_back_q) begin
						cur_row_q  <= prev_row;
						cur_col_q  <= prev_col;
						back_arr_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			item_open_q <= item_openings;
		end
		if (state_q == ST_ROW) begin
			row_n_q <= vis_rd_a;
			row_s_q <= vis_rd_b;
		end
	end

`ifndef SYNTHESIS
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> stack_depth_q == '0)
		else $error("finished with a non-empty path stack");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stack_depth_q <= STACK_FULL)
		else $error("path stack depth out of range");

	a_back_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_back_q && res_done_q))
		else $error("result both backtracked and done");

	a_out_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |=> state_q == ST_IDLE)
		else $error("sequencer did not return to idle after result");

	a_back_loads_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(res_fire && res_back_q) |=> back_arr_q)
		else $error("backstep did not mark backward arrival");
`endif

endmodule

@@ src/dfs_maze_explorer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_maze_explorer_unit
// Depth-first maze explorer: one move result per openings item.
// After an item is accepted the sequencer passes its row-read, decide and
// output states, then the result is registered onto m_tvalid; once finished
// it goes from idle straight to output. It handles one item at a time, in a
// read-decide-write sequence over the visited row memory and the path stack.
// Reset: asynchronous; visited map, stack depth, count and position clear
// at once, start registers return to row 1, column 1.
// ----------------------------------------------------------------------------
module dfs_maze_explorer_unit import dme_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [IN_TDATA_W-1:0]   s_tdata,   // openings
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_TDATA_W-1:0]  m_tdata,   // move_dir, new_row, new_col, mapped_cells
	output logic [OUT_TUSER_W-1:0]  m_tuser,   // backtracked, explore_done
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  coord_t                  cfg_data
);

	coord_t     start_row_q;
	coord_t     start_col_q;
	logic       in_full_q;
	open_t      in_open_q;
	logic       out_valid_q;
	result_t    out_res_q;

	logic       item_take;
	logic       res_valid;
	logic       res_ready;
	result_t    res;
	vis_req_t   vis_req;
	row_t       vis_rd_a;
	row_t       vis_rd_b;
	store_req_t st_req;
	open_t      opn_rdata;
	cell_t      stk_rdata;

	assign cfg_ready = 1'b1;
	assign s_tready  = !in_full_q;
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q <= START_DEFAULT;
			start_col_q <= START_DEFAULT;
			in_full_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_START_ROW: start_row_q <= cfg_data;
					CFG_START_COL: start_col_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				in_full_q <= 1'b1;
			end else if (item_take) begin
				in_full_q <= 1'b0;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_open_q <= s_tdata[OPEN_BITS-1:0];
		end
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	dme_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start_row     (start_row_q),
		.start_col     (start_col_q),
		.item_valid    (in_full_q),
		.item_openings (in_open_q),
		.item_take     (item_take),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.vis_req       (vis_req),
		.vis_rd_a      (vis_rd_a),
		.vis_rd_b      (vis_rd_b),
		.st_req        (st_req),
		.opn_rdata     (opn_rdata),
		.stk_rdata     (stk_rdata)
	);

	dme_visited u_visited (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (vis_req),
		.rd_a   (vis_rd_a),
		.rd_b   (vis_rd_b)
	);

	dme_store u_store (
		.clk       (clk),
		.req       (st_req),
		.opn_rdata (opn_rdata),
		.stk_rdata (stk_rdata)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_res_q.mapped_cells, out_res_q.new_col,
		out_res_q.new_row, out_res_q.move_dir});
	assign m_tuser  = {out_res_q.explore_done, out_res_q.backtracked};

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the depth-first maze explorer. A random connected maze with
// a few loops and random openings on the outer edge drives the explorer
// from a corner start cell until the whole run returns to the start, with
// some random noise items mixed in. An in-bench predictor tracks the
// visited map, path stack and position, and every move item is checked
// field by field. Start registers are written at several settings before
// the run, and again once it has finished, when they must have no effect.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import dme_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAZE_ITEMS  = 1028;

	typedef struct packed {
		logic  from_maze;
		open_t openings;
	} sense_item_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic [OUT_TUSER_W-1:0]  m_tuser;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	coord_t                  cfg_data;

	dfs_maze_explorer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// explorer state as predicted
	coord_t  start_row, start_col;
	logic    vis_map   [GRID_CELLS];
	open_t   cell_open [GRID_CELLS];
	cell_t   path_stk  [GRID_CELLS];
	depth_t  stk_depth;
	coord_t  cur_row, cur_col;
	logic    back_arr, started, explored;
	depth_t  mapped;

	open_t       maze_open [GRID_CELLS];
	result_t     predicted_moves [$];
	sense_item_t sensor_q [$];
	sense_item_t nxt_item;
	result_t     want;
	int          gap_left, stall_left, fail_cnt, cyc;
	logic        calm;

	always #5 clk = ~clk;

	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (pick < 45)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic carve(input int r, input int c, input dir_t d);
		case (d)
			DIR_N: if (r > 0) begin
				maze_open[{coord_t'(r), coord_t'(c)}][DIR_N] = 1'b1;
				maze_open[{coord_t'(r - 1), coord_t'(c)}][DIR_S] = 1'b1;
			end
			DIR_E: if (c < SIDE - 1) begin
				maze_open[{coord_t'(r), coord_t'(c)}][DIR_E] = 1'b1;
				maze_open[{coord_t'(r), coord_t'(c + 1)}][DIR_W] = 1'b1;
			end
			DIR_S: if (r < SIDE - 1) begin
				maze_open[{coord_t'(r), coord_t'(c)}][DIR_S] = 1'b1;
				maze_open[{coord_t'(r + 1), coord_t'(c)}][DIR_N] = 1'b1;
			end
			default: if (c > 0) begin
				maze_open[{coord_t'(r), coord_t'(c)}][DIR_W] = 1'b1;
				maze_open[{coord_t'(r), coord_t'(c - 1)}][DIR_E] = 1'b1;
			end
		endcase
	endtask

	// one explorer step for an accepted openings item
	task automatic explore_step(input open_t sensed);
		result_t res;
		cell_t   here, prev;
		open_t   op;
		coord_t  nr, nc, pr, pc;
		logic    moved, in_grid;
		res   = '0;
		moved = 1'b0;
		if (explored) begin
			res.explore_done = 1'b1;
		end else begin
			if (!started) begin
				started  = 1'b1;
				cur_row  = start_row;
				cur_col  = start_col;
				back_arr = 1'b0;
			end
			here = {cur_row, cur_col};
			if (!back_arr) begin
				cell_open[here] = sensed;
				if (!vis_map[here]) begin
					vis_map[here] = 1'b1;
					mapped++;
				end
				if (stk_depth < STACK_FULL) begin
					path_stk[stk_depth] = here;
					stk_depth++;
				end
			end
			op = cell_open[here];
			for (int d = 0; d < 4; d++) begin
				if (!moved && op[d]) begin
					nr      = cur_row;
					nc      = cur_col;
					in_grid = 1'b1;
					case (dir_t'(d))
						DIR_N: if (cur_row == 0) in_grid = 1'b0; else nr = cur_row - coord_t'(1);
						DIR_E: if (cur_col == SIDE - 1) in_grid = 1'b0; else nc = cur_col + coord_t'(1);
						DIR_S: if (cur_row == SIDE - 1) in_grid = 1'b0; else nr = cur_row + coord_t'(1);
						default: if (cur_col == 0) in_grid = 1'b0; else nc = cur_col - coord_t'(1);
					endcase
					if (in_grid && !vis_map[{nr, nc}]) begin
						res.move_dir = dir_t'(d);
						cur_row      = nr;
						cur_col      = nc;
						back_arr     = 1'b0;
						moved        = 1'b1;
					end
				end
			end
			if (!moved) begin
				if (stk_depth > 0)
					stk_depth--;
				if (stk_depth == 0) begin
					explored         = 1'b1;
					res.explore_done = 1'b1;
				end else begin
					prev = path_stk[stk_depth - 1];
					pr   = prev[CELL_BITS-1:COORD_BITS];
					pc   = prev[COORD_BITS-1:0];
					if (pr + 1 == cur_row && pc == cur_col)
						res.move_dir = DIR_N;
					else if (pr == cur_row && pc == cur_col + 1)
						res.move_dir = DIR_E;
					else if (pr == cur_row + 1 && pc == cur_col)
						res.move_dir = DIR_S;
					else if (pr == cur_row && pc + 1 == cur_col)
						res.move_dir = DIR_W;
					else
						res.move_dir = DIR_N;
					cur_row         = pr;
					cur_col         = pc;
					back_arr        = 1'b1;
					res.backtracked = 1'b1;
				end
			end
		end
		res.new_row      = cur_row;
		res.new_col      = cur_col;
		res.mapped_cells = mapped;
		predicted_moves.push_back(res);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input coord_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_START_ROW)
			start_row = val;
		else
			start_col = val;
		cfg_valid <= 1'b0;
	endtask

	// wait for the block to drain, then let its pipeline run empty
	task automatic settle();
		do @(negedge clk); while (sensor_q.size() > 0 || s_tvalid || predicted_moves.size() > 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s expected %0d got %0d", name, exp_v, got_v);
			fail_cnt++;
		end
	endfunction

	// openings driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				explore_step(s_tdata[OPEN_BITS-1:0]);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (sensor_q.size() > 0) begin
					nxt_item = sensor_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {{(IN_TDATA_W - OPEN_BITS){1'b0}},
						nxt_item.from_maze ? maze_open[{cur_row, cur_col}] : nxt_item.openings};
					gap_left = idle_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					stall_left = idle_len();
			end
		end
	end

	// move item monitor
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (predicted_moves.size() == 0) begin
				$error("move item with no prediction waiting");
				fail_cnt++;
			end else begin
				want = predicted_moves.pop_front();
				check_field("move_dir", 32'(want.move_dir), 32'(m_tdata[1:0]));
				check_field("new_row", 32'(want.new_row), 32'(m_tdata[2 +: COORD_BITS]));
				check_field("new_col", 32'(want.new_col),
					32'(m_tdata[2 + COORD_BITS +: COORD_BITS]));
				check_field("mapped_cells", 32'(want.mapped_cells),
					32'(m_tdata[2 + 2 * COORD_BITS +: DEPTH_BITS]));
				check_field("backtracked", 32'(want.backtracked), 32'(m_tuser[0]));
				check_field("explore_done", 32'(want.explore_done), 32'(m_tuser[1]));
			end
		end
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0)
			calm <= ~calm;
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_START_ROW;
		cfg_data   = '0;
		calm       = 1'b0;
		gap_left   = 0;
		stall_left = 0;
		fail_cnt   = 0;
		cyc        = 0;
		start_row  = START_DEFAULT;
		start_col  = START_DEFAULT;
		stk_depth  = '0;
		cur_row    = '0;
		cur_col    = '0;
		back_arr   = 1'b0;
		started    = 1'b0;
		explored   = 1'b0;
		mapped     = '0;
		for (int i = 0; i < GRID_CELLS; i++) begin
			vis_map[i]   = 1'b0;
			maze_open[i] = '0;
		end

		// spanning tree maze, each cell but the north-east corner joined north or east, plus some loops
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				if (r > 0 && (c == SIDE - 1 || $urandom_range(0, 1)))
					carve(r, c, DIR_N);
				else
					carve(r, c, DIR_E);
			end
		end
		repeat (24)
			carve($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
				dir_t'($urandom_range(0, 3)));
		// openings that point off the grid
		for (int k = 0; k < SIDE; k++) begin
			maze_open[{coord_t'(0), coord_t'(k)}][DIR_N]        = 1'($urandom_range(0, 1));
			maze_open[{coord_t'(SIDE - 1), coord_t'(k)}][DIR_S] = 1'($urandom_range(0, 1));
			maze_open[{coord_t'(k), coord_t'(0)}][DIR_W]        = 1'($urandom_range(0, 1));
			maze_open[{coord_t'(k), coord_t'(SIDE - 1)}][DIR_E] = 1'($urandom_range(0, 1));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(CFG_START_ROW, coord_t'(SIDE - 1));
		write_reg(CFG_START_COL, '0);
		write_reg(CFG_START_ROW, '0);
		write_reg(CFG_START_COL, coord_t'(SIDE - 1));
		write_reg(CFG_START_ROW, $urandom_range(0, 1) ? coord_t'(SIDE - 1) : coord_t'(0));
		write_reg(CFG_START_COL, $urandom_range(0, 1) ? coord_t'(SIDE - 1) : coord_t'(0));

		// corner start with every opening set, then the maze walk with some noise
		sensor_q.push_back('{from_maze: 1'b0, openings: 4'hF});
		for (int i = 0; i < MAZE_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 8)
				sensor_q.push_back('{from_maze: 1'b0, openings: open_t'($urandom_range(0, 15))});
			else
				sensor_q.push_back('{from_maze: 1'b1, openings: '0});
		end
		settle();

		// start registers have no effect once the run has begun
		write_reg(CFG_START_ROW, coord_t'(SIDE - 1));
		write_reg(CFG_START_COL, coord_t'(SIDE - 1));
		sensor_q.push_back('{from_maze: 1'b0, openings: 4'h0});
		sensor_q.push_back('{from_maze: 1'b0, openings: 4'hF});
		repeat (10)
			sensor_q.push_back('{from_maze: 1'b0, openings: open_t'($urandom_range(0, 15))});
		settle();

		write_reg(CFG_START_ROW, '0);
		write_reg(CFG_START_COL, '0);
		repeat (10)
			sensor_q.push_back('{from_maze: 1'b0, openings: open_t'($urandom_range(0, 15))});
		settle();

		if (fail_cnt == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

@@ dfs_maze_explorer_unit.f @@
src/dme_pkg.sv
src/dme_visited.sv
src/dme_store.sv
src/dme_seq.sv
src/dfs_maze_explorer_unit.sv
dv/tb_top.sv
